@@ rtl/bfs_pkg.sv @@
// Shared types and constants for the bounded FIFO with statistics.
// Used by bfs_ctrl and bounded_fifo_with_stats_top; depends on nothing.
`default_nettype none

package bfs_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CtrW   = 32;
  localparam int unsigned CntW   = 5;

  localparam logic [CntW-1:0] LimitReset = 5'd16;

  typedef enum logic {
    KIND_ADD = 1'b0,
    KIND_GET = 1'b1
  } kind_e;

  // Status of the beat that is on the result ports.
  typedef struct packed {
    logic            valid;
    logic            accepted;
    logic            was_get;
    logic [CntW-1:0] occupancy;
    logic [CtrW-1:0] add_tries;
    logic [CtrW-1:0] get_tries;
    logic [CtrW-1:0] adds_done;
    logic [CtrW-1:0] gets_done;
  } bfs_result_t;

endpackage

`default_nettype wire

@@ rtl/bounded_fifo_with_stats_top.sv @@
// Top level of the bounded FIFO with statistics counters.
// Instantiates bfs_ctrl and bfs_ring_mem; depends on bfs_pkg.
`default_nettype none

// A first-in first-out queue of signed 32-bit values with a programmable
// occupancy limit and four wrapping 32-bit statistics counters. An item is
// taken when start is high and busy is low; kind_i selects add (0) or get (1).
// Every item gives exactly one result beat, in the cycle after it was taken,
// marked by done_o for a single cycle; the receiver cannot hold it off.
// When an item is taken the ring store is written (add) or read (get) and
// all pointers and counters update; in the cycle after, the store's registered
// read data reaches value_out_o while busy is high. A new item is not taken
// while the last one's result beat is on the ports. An add is refused when the
// queue holds at least min(entry_limit, DEPTH) entries, a get when the queue is
// empty; refused items still count as tries and report value_out_o as zero.
// The limit is written through cfg_valid_i / cfg_data_i (always ready); the
// user must write it only while the block is idle, as the block itself does
// not enforce this. It resets to 16. The ring store needs no clearing pass
// after reset, since a get only reads entries written by earlier adds.
module bounded_fifo_with_stats_top
  import bfs_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    kind_i,
  input  wire logic signed [DataW-1:0] value_in_i,
  output logic                         done_o,
  output logic                         accepted_o,
  output logic signed      [DataW-1:0] value_out_o,
  output logic             [CntW-1:0]  occupancy_o,
  output logic             [CtrW-1:0]  add_tries_o,
  output logic             [CtrW-1:0]  get_tries_o,
  output logic             [CtrW-1:0]  adds_done_o,
  output logic             [CtrW-1:0]  gets_done_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic        [CntW-1:0]  cfg_data_i
);

  // A single-entry ring still needs a one-bit address.
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bfs_result_t      result;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [DataW-1:0] wr_data, rd_data;

  bfs_ctrl #(
    .Depth (DEPTH),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_e'(kind_i)),
    .value_in_i  (value_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .result_o    (result)
  );

  bfs_ring_mem #(
    .Depth (DEPTH),
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_ring_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The block is busy exactly while a result beat is on the ports.
  assign busy        = result.valid;
  assign cfg_ready_o = 1'b1;

  assign done_o      = result.valid;
  assign accepted_o  = result.accepted;
  // Only a successful get shows stored data; everything else reports zero.
  assign value_out_o = (result.accepted && result.was_get) ? rd_data : '0;
  assign occupancy_o = result.occupancy;
  assign add_tries_o = result.add_tries;
  assign get_tries_o = result.get_tries;
  assign adds_done_o = result.adds_done;
  assign gets_done_o = result.gets_done;

endmodule

`default_nettype wire

@@ rtl/bfs_ring_mem.sv @@
// Ring store of the FIFO: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module bfs_ring_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bfs_ctrl.sv @@
// Queue control: head and tail pointers, entry count, limit register and
// statistics counters. Drives the ring store ports. Depends on bfs_pkg.
`default_nettype none

module bfs_ctrl
  import bfs_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire kind_e            kind_i,
  input  wire logic [DataW-1:0] value_in_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [CntW-1:0]  cfg_data_i,
  output logic                  wr_en_o,
  output logic      [AddrW-1:0] wr_addr_o,
  output logic      [DataW-1:0] wr_data_o,
  output logic                  rd_en_o,
  output logic      [AddrW-1:0] rd_addr_o,
  output bfs_result_t           result_o
);

  localparam logic [AddrW-1:0] LastSlot = AddrW'(Depth - 1);

  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d, limit_q;
  logic [CtrW-1:0]  add_tries_q, add_tries_d, get_tries_q, get_tries_d;
  logic [CtrW-1:0]  adds_done_q, adds_done_d, gets_done_q, gets_done_d;
  logic             pending_q, ok_q, ok_d, was_get_q;
  logic             accept, add_ok, get_ok;

  assign accept = start_i && !pending_q;

  // The limit saturates at the ring depth.
  assign add_ok = (kind_i == KIND_ADD) && (count_q < limit_q)
                  && (32'(count_q) < 32'(Depth));
  assign get_ok = (kind_i == KIND_GET) && (count_q != '0);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    add_tries_d = add_tries_q;
    get_tries_d = get_tries_q;
    adds_done_d = adds_done_q;
    gets_done_d = gets_done_q;
    ok_d        = 1'b0;
    if (accept) begin
      unique case (kind_i)
        KIND_ADD: begin
          add_tries_d = add_tries_q + CtrW'(1);
          if (add_ok) begin
            tail_d      = (tail_q == LastSlot) ? '0 : tail_q + AddrW'(1);
            count_d     = count_q + CntW'(1);
            adds_done_d = adds_done_q + CtrW'(1);
            ok_d        = 1'b1;
          end
        end
        KIND_GET: begin
          get_tries_d = get_tries_q + CtrW'(1);
          if (get_ok) begin
            head_d      = (head_q == LastSlot) ? '0 : head_q + AddrW'(1);
            count_d     = count_q - CntW'(1);
            gets_done_d = gets_done_q + CtrW'(1);
            ok_d        = 1'b1;
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  assign wr_en_o   = accept && add_ok;
  assign wr_addr_o = tail_q;
  assign wr_data_o = value_in_i;
  assign rd_en_o   = accept && get_ok;
  assign rd_addr_o = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      limit_q     <= LimitReset;
      add_tries_q <= '0;
      get_tries_q <= '0;
      adds_done_q <= '0;
      gets_done_q <= '0;
      pending_q   <= 1'b0;
      ok_q        <= 1'b0;
      was_get_q   <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      add_tries_q <= add_tries_d;
      get_tries_q <= get_tries_d;
      adds_done_q <= adds_done_d;
      gets_done_q <= gets_done_d;
      pending_q   <= accept;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        ok_q      <= ok_d;
        was_get_q <= (kind_i == KIND_GET);
      end
    end
  end

  always_comb begin
    result_o.valid     = pending_q;
    result_o.accepted  = ok_q;
    result_o.was_get   = was_get_q;
    result_o.occupancy = count_q;
    result_o.add_tries = add_tries_q;
    result_o.get_tries = get_tries_q;
    result_o.adds_done = adds_done_q;
    result_o.gets_done = gets_done_q;
  end

  // The entry count never exceeds the ring depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(Depth))
    else $error("entry count above ring depth");

  // Count matches successful adds minus successful gets, modulo the count width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'(adds_done_q - gets_done_q))
    else $error("entry count out of step with done counters");

  // Every accepted item gives exactly one result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (pending_q && !accept))
    else $error("accepted item did not give a single result beat");

  // The ring store is never read and written together, and is accessed only for an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_o && rd_en_o) && (!(wr_en_o || rd_en_o) || accept))
    else $error("ring store access outside an accepted item");

endmodule

`default_nettype wire

@@ bench/tb_bounded_fifo_with_stats_top.sv @@
// Self-checking testbench for bounded_fifo_with_stats_top.
// Needs bfs_pkg and the block's RTL; it has its own queue and counter predictor.
`timescale 1ns / 100ps

module tb_bounded_fifo_with_stats_top;
  import bfs_pkg::*;

  localparam int Depth         = 16;
  localparam int SettleCycles  = 3;       // settling margin after every result beat is back
  localparam int MaxReports    = 10;
  localparam int PhaseCount    = 12;
  localparam int PhaseItems    = 119;
  localparam int TimeoutNs     = 2000000;

  // Work that the driver pulls in order: a command beat, a write of the
  // limit register, or a pause until every outstanding result has returned.
  typedef enum logic [1:0] {
    OP_ITEM,
    OP_LIMIT,
    OP_DRAIN
  } op_tag_e;

  typedef struct {
    op_tag_e            tag;
    kind_e              kind;
    logic [DataW-1:0]   value;
    logic [CntW-1:0]    limit;
    int unsigned        gap;
  } fifo_op_t;

  // Everything a result beat carries, as the predictor computes it.
  typedef struct packed {
    logic               accepted;
    logic [DataW-1:0]   value_out;
    logic [CntW-1:0]    occupancy;
    logic [CtrW-1:0]    add_tries;
    logic [CtrW-1:0]    get_tries;
    logic [CtrW-1:0]    adds_done;
    logic [CtrW-1:0]    gets_done;
  } fifo_beat_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start       = 1'b0;
  logic                     busy;
  kind_e                    kind_d      = KIND_ADD;
  logic signed [DataW-1:0]  value_in_d  = '0;
  logic                     done_o;
  logic                     accepted_o;
  logic signed [DataW-1:0]  value_out_o;
  logic        [CntW-1:0]   occupancy_o;
  logic        [CtrW-1:0]   add_tries_o;
  logic        [CtrW-1:0]   get_tries_o;
  logic        [CtrW-1:0]   adds_done_o;
  logic        [CtrW-1:0]   gets_done_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic        [CntW-1:0]   cfg_data_i  = '0;

  fifo_op_t    pending_ops[$];
  fifo_beat_t  expected_beats[$];

  // Predictor state: a shadow of the ring, its pointers and the counters.
  logic [DataW-1:0]  shadow_ring [Depth];
  int                shadow_head     = 0;
  int                shadow_tail     = 0;
  logic [CntW-1:0]   shadow_count    = '0;
  logic [CtrW-1:0]   add_try_ctr     = '0;
  logic [CtrW-1:0]   get_try_ctr     = '0;
  logic [CtrW-1:0]   add_done_ctr    = '0;
  logic [CtrW-1:0]   get_done_ctr    = '0;
  logic [CntW-1:0]   entry_limit_q   = LimitReset;

  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned fail_count    = 0;
  int unsigned limit_writes  = 0;
  int unsigned full_refusals = 0;
  int unsigned empty_refusals = 0;
  int unsigned quiet_cycles  = 0;

  always #2 clk_i = ~clk_i;

  bounded_fifo_with_stats_top #(
    .DEPTH(Depth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .kind_i     (kind_d),
    .value_in_i (value_in_d),
    .done_o     (done_o),
    .accepted_o (accepted_o),
    .value_out_o(value_out_o),
    .occupancy_o(occupancy_o),
    .add_tries_o(add_tries_o),
    .get_tries_o(get_tries_o),
    .adds_done_o(adds_done_o),
    .gets_done_o(gets_done_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Applies one command to the shadow queue and returns the beat it must
  // produce. The limit saturates at the ring depth; a limit at or below the
  // current occupancy refuses adds, and a refused command still counts as a try.
  function automatic fifo_beat_t fifo_step_outcome(kind_e kind, logic [DataW-1:0] value);
    fifo_beat_t       beat;
    logic [CntW-1:0]  cap;
    beat = '0;
    cap  = (entry_limit_q > Depth) ? CntW'(Depth) : entry_limit_q;
    if (kind == KIND_ADD) begin
      add_try_ctr = add_try_ctr + 1'b1;
      if (shadow_count < cap) begin
        shadow_ring[shadow_tail] = value;
        shadow_tail  = (shadow_tail == Depth - 1) ? 0 : shadow_tail + 1;
        shadow_count = shadow_count + 1'b1;
        add_done_ctr = add_done_ctr + 1'b1;
        beat.accepted = 1'b1;
      end else begin
        full_refusals++;
      end
    end else begin
      get_try_ctr = get_try_ctr + 1'b1;
      if (shadow_count != 0) begin
        beat.value_out = shadow_ring[shadow_head];
        shadow_head  = (shadow_head == Depth - 1) ? 0 : shadow_head + 1;
        shadow_count = shadow_count - 1'b1;
        get_done_ctr = get_done_ctr + 1'b1;
        beat.accepted = 1'b1;
      end else begin
        empty_refusals++;
      end
    end
    beat.occupancy = shadow_count;
    beat.add_tries = add_try_ctr;
    beat.get_tries = get_try_ctr;
    beat.adds_done = add_done_ctr;
    beat.gets_done = get_done_ctr;
    return beat;
  endfunction

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      log_failure($sformatf("beat %0d %s expected %08h got %08h",
                            results_seen, field, want, got));
    end
  endtask

  // Driver. A command stays on the ports until the block takes it (start high
  // while busy is low); the prediction is made at that same edge from the
  // values that were on the ports. Limit writes and drain pauses wait until
  // every issued command has returned its beat, then a few quiet cycles.
  always @(posedge clk_i) begin : drive_proc
    logic      nxt_start;
    logic      nxt_cfg;
    fifo_op_t  head_op;
    if (rst_ni) begin
      nxt_start = start;
      nxt_cfg   = cfg_valid_i;
      if (start && !busy) begin
        expected_beats.push_back(fifo_step_outcome(kind_d, value_in_d));
        items_sent++;
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        entry_limit_q = cfg_data_i;
        limit_writes++;
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && pending_ops.size() > 0) begin
        head_op = pending_ops[0];
        if (head_op.tag == OP_ITEM) begin
          if (head_op.gap > 0) begin
            pending_ops[0].gap = head_op.gap - 1;
          end else begin
            kind_d     <= head_op.kind;
            value_in_d <= head_op.value;
            nxt_start  = 1'b1;
            void'(pending_ops.pop_front());
          end
        end else if (items_sent != results_seen) begin
          quiet_cycles = 0;
        end else if (quiet_cycles < SettleCycles) begin
          quiet_cycles++;
        end else begin
          quiet_cycles = 0;
          if (head_op.tag == OP_LIMIT) begin
            cfg_data_i <= head_op.limit;
            nxt_cfg    = 1'b1;
          end
          void'(pending_ops.pop_front());
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // Monitor. A result beat lasts exactly one cycle under done_o and cannot be
  // held off, so every strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin : watch_proc
    fifo_beat_t want;
    if (rst_ni && done_o) begin
      if (expected_beats.size() == 0) begin
        log_failure($sformatf("result beat with nothing expected, occupancy %0d",
                              occupancy_o));
      end else begin
        want = expected_beats.pop_front();
        compare_field("accepted",  32'(want.accepted),  32'(accepted_o));
        compare_field("value_out", want.value_out,      value_out_o);
        compare_field("occupancy", 32'(want.occupancy), 32'(occupancy_o));
        compare_field("add_tries", want.add_tries,      add_tries_o);
        compare_field("get_tries", want.get_tries,      get_tries_o);
        compare_field("adds_done", want.adds_done,      adds_done_o);
        compare_field("gets_done", want.gets_done,      gets_done_o);
        results_seen <= results_seen + 1;
      end
    end
  end

  task automatic queue_item(kind_e kind, logic [DataW-1:0] value, int unsigned gap);
    fifo_op_t op;
    op = '{tag: OP_ITEM, kind: kind, value: value, limit: '0, gap: gap};
    pending_ops.push_back(op);
  endtask

  task automatic queue_limit(logic [CntW-1:0] limit);
    fifo_op_t op;
    op = '{tag: OP_LIMIT, kind: KIND_ADD, value: '0, limit: limit, gap: 0};
    pending_ops.push_back(op);
  endtask

  task automatic queue_drain();
    fifo_op_t op;
    op = '{tag: OP_DRAIN, kind: KIND_ADD, value: '0, limit: '0, gap: 0};
    pending_ops.push_back(op);
  endtask

  // Idle cycles before a command: mostly none, sometimes a few, rarely many.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  // Data words: fully random, with the two's complement corners mixed in.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 39))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stim_proc
    logic [CntW-1:0]  limit_plan [7];
    int               add_pct;
    int               run_left;
    int               drain_at;
    bit               quiet;
    kind_e            run_kind;
    kind_e            k;

    limit_plan = '{5'd31, 5'd16, 5'd0, 5'd1, 5'd17, 5'd15, 5'd8};

    // Directed part, starting from the reset limit of 16.
    // A get on an empty queue is refused and reports zero.
    queue_item(KIND_GET, 32'hFFFF_FFFF, 0);
    // The data corners go through the ring and come back in order; the data
    // presented with a get must be ignored.
    queue_item(KIND_ADD, 32'h7FFF_FFFF, 0);
    queue_item(KIND_ADD, 32'h8000_0000, 1);
    queue_item(KIND_ADD, 32'h0000_0000, 0);
    queue_item(KIND_ADD, 32'hFFFF_FFFF, 0);
    queue_item(KIND_GET, 32'h0000_0000, 0);
    queue_item(KIND_GET, 32'hFFFF_FFFF, 2);
    queue_item(KIND_GET, 32'h7FFF_FFFF, 0);
    queue_item(KIND_GET, 32'h8000_0000, 0);
    queue_item(KIND_GET, 32'h1234_5678, 0);
    // With a limit of zero every add is refused.
    queue_limit(5'd0);
    queue_item(KIND_ADD, 32'h5A5A_5A5A, 0);
    queue_item(KIND_GET, 32'hA5A5_A5A5, 0);
    // Fill up to a small limit, then one add too many.
    queue_limit(5'd2);
    queue_item(KIND_ADD, 32'h0000_0001, 0);
    queue_item(KIND_ADD, 32'hFFFF_FFFE, 0);
    queue_item(KIND_ADD, 32'h0000_0003, 0);
    // Limit lowered below the occupancy: adds stay refused until gets bring
    // the occupancy under the limit again.
    queue_limit(5'd1);
    queue_item(KIND_ADD, 32'h0000_0004, 0);
    queue_item(KIND_GET, 32'h0000_0000, 0);
    queue_item(KIND_ADD, 32'h0000_0005, 3);
    queue_item(KIND_GET, 32'h0000_0000, 0);
    queue_item(KIND_ADD, 32'h0000_0006, 0);
    queue_item(KIND_GET, 32'h0000_0000, 0);

    // Random part in phases, one limit per phase. Commands come in runs of
    // mostly one kind so the queue regularly hits both full and empty; the
    // first phase leans hard on adds with a limit above the depth, which
    // exercises the saturation. Every third phase runs without idle cycles,
    // and each phase has one pause where the sender lets the block drain.
    for (int p = 0; p < PhaseCount; p++) begin
      queue_limit((p < 7) ? limit_plan[p] : CntW'($urandom_range(0, 31)));
      quiet    = (p % 3 == 1);
      add_pct  = (p == 0) ? 85 : ((p % 3 == 0) ? 70 : ((p % 3 == 1) ? 50 : 30));
      drain_at = $urandom_range(20, 100);
      run_left = 0;
      run_kind = KIND_ADD;
      for (int i = 0; i < PhaseItems; i++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 20);
          run_kind = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_GET;
        end
        if ($urandom_range(0, 99) < 85) begin
          k = run_kind;
        end else begin
          k = (run_kind == KIND_ADD) ? KIND_GET : KIND_ADD;
        end
        queue_item(k, pick_value(), pick_gap(quiet));
        run_left--;
        if (i == drain_at) begin
          queue_drain();
        end
      end
    end
    // Put the limit back to its reset value at the end.
    queue_limit(LimitReset);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until everything has been issued and every beat has come back,
    // then give the block a few more cycles to show any stray beat.
    while (pending_ops.size() != 0 || start || cfg_valid_i || items_sent != results_seen) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles + 2) @(posedge clk_i);

    if (expected_beats.size() != 0) begin
      log_failure($sformatf("%0d expected beats never arrived", expected_beats.size()));
    end
    $display("Covered %0d commands (%0d adds refused, %0d gets refused), %0d limit writes.",
             items_sent, full_refusals, empty_refusals, limit_writes);
    $display("Checked %0d result beats, %0d failures.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog_proc
    #(TimeoutNs);
    $display("Timed out with %0d commands pending and %0d beats outstanding.",
             pending_ops.size(), expected_beats.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
